@@ rtl/audio_frame_tick_accumulator_assert.svh @@
// Assertion macros shared by the frame tick accumulator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef AUDIO_FRAME_TICK_ACCUMULATOR_ASSERT_SVH
`define AUDIO_FRAME_TICK_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define AFT_ASSERT_IMP(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define AFT_ASSERT_NXT(lbl, clk, rst_n, a, b, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

@@ rtl/aft_pkg.sv @@
// Shared widths, register indexes and divider interface types for the
// frame tick accumulator. Depends on nothing.
package aft_pkg;

    // Field widths.
    localparam int RATE_W      = 20;
    localparam int TPS_W       = 16;
    localparam int FRAMES_W    = 20;
    localparam int QUOT_W      = 21;
    localparam int EMIT_W      = 48;
    localparam int TOTAL_WIDTH = 48;

    // Divider sizing: the dividend is remainder plus sample rate.
    localparam int DIVIDEND_W = QUOT_W;
    localparam int REM_W      = TPS_W;
    localparam int CNT_W      = $clog2(DIVIDEND_W);

    // Stream and configuration port sizing.
    localparam int S_DATA_W = ((TPS_W + FRAMES_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((QUOT_W + EMIT_W + 1 + 7) / 8) * 8;
    localparam int APB_W    = 32;
    localparam int ADDR_W   = 3;
    localparam int IDX_W    = ADDR_W - 2;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_AUDIO_RATE = 1'b0;

    // Input item kinds carried in tuser.
    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_RENDER = 1'b1;

    // Request into the shared divider.
    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [TPS_W-1:0]      divisor;
    } t_div_req;

    // Response from the shared divider.
    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [REM_W-1:0]      remainder;
    } t_div_rsp;

endpackage

@@ rtl/aft_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on aft_pkg and the shared assertion macro header.
`include "audio_frame_tick_accumulator_assert.svh"

module aft_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aft_pkg::t_div_req i_req,
    output aft_pkg::t_div_rsp o_rsp
);
    import aft_pkg::*;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [REM_W-1:0]      r_rem;
    logic [TPS_W-1:0]      r_dvs;

    logic [REM_W:0]        shifted;
    logic [REM_W:0]        diff;
    logic                  ge;

    // Shift in the next dividend bit and try one subtraction.
    always_comb begin
        shifted = {r_rem, r_quo[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, r_dvs};
        ge      = (shifted >= {1'b0, r_dvs});
    end

    // Control: busy for one step per dividend bit, done pulses after the last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (!r_busy && i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load operands on start, then one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!r_busy && i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
            r_rem <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
        end
    end

    always_comb begin
        o_rsp.busy      = r_busy;
        o_rsp.done      = r_done;
        o_rsp.quotient  = r_quo;
        o_rsp.remainder = r_rem;
    end

    // The partial remainder never reaches the divisor.
    `AFT_ASSERT_IMP(a_rem_below_dvs, i_clk, i_rst_n, r_busy, r_rem < r_dvs, "remainder >= divisor")
    // A start while idle makes the unit busy.
    `AFT_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, i_req.start && !r_busy, r_busy, "start not taken")
    // Done is only raised after the unit stops.
    `AFT_ASSERT_IMP(a_done_idle, i_clk, i_rst_n, r_done, !r_busy, "done while busy")

endmodule

@@ rtl/audio_frame_tick_accumulator.sv @@
// Top level of the frame tick accumulator: sequencer, state, registers and ports.
// Depends on aft_pkg, aft_divider and the shared assertion macro header.
//
//  Port group   Direction  Role
//  s_t*         in         input item: tdata, tuser (mode)
//  m_t*         out        result item: tdata
//  p*           in/out     APB configuration, audio rate register at address 0
//
// A tick item passes through accept, 21 divider steps (one quotient bit each
// in the shared restoring divider), the done pulse and the load into the
// output register; a render item or a tick without division skips the divider.
// Reset clears the sample rate, remainder, total and all handshake state.
// The output register lets the next item be accepted while a result waits;
// a stalled result stops only the load of the following result.
`include "audio_frame_tick_accumulator_assert.svh"

module audio_frame_tick_accumulator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input item stream.
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [15:0] tick_rate, [35:16] rendered_frames, [39:36] zero
    input  logic [aft_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] mode
    input  logic                          s_tuser,
    // Result item stream.
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [20:0] frames_this_tick, [68:21] emitted_total, [69] configured, [71:70] zero
    output logic [aft_pkg::M_DATA_W-1:0]  m_tdata,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aft_pkg::ADDR_W-1:0]    paddr,
    input  logic [aft_pkg::APB_W-1:0]     pwdata,
    output logic [aft_pkg::APB_W-1:0]     prdata,
    output logic                          pready
);
    import aft_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state                 r_state;
    t_state                 n_state;
    logic [RATE_W-1:0]      r_rate;
    logic [REM_W-1:0]       r_rem;
    logic [TOTAL_WIDTH-1:0] r_total;
    logic [QUOT_W-1:0]      r_quot;
    logic                   r_out_valid;
    logic [M_DATA_W-1:0]    r_out_data;

    logic                   in_acc;
    logic                   in_mode;
    logic [TPS_W-1:0]       in_tps;
    logic [FRAMES_W-1:0]    in_frames;
    logic                   need_div;
    logic                   cfg_wr;
    logic                   can_load;
    logic [63:0]            total_wide;
    t_div_req               div_req;
    t_div_rsp               div_rsp;

    // Input unpacking and handshake; no item is taken while reset is held.
    always_comb begin
        in_mode   = s_tuser;
        in_tps    = s_tdata[TPS_W-1:0];
        in_frames = s_tdata[TPS_W+FRAMES_W-1:TPS_W];
        s_tready  = i_rst_n && (r_state == S_IDLE);
        in_acc    = s_tvalid && s_tready;
        need_div  = (in_mode == MODE_TICK) && (r_rate != '0) && (in_tps != '0);
        can_load  = !r_out_valid || m_tready;
    end

    // Divider request: remainder plus sample rate over the tick rate.
    always_comb begin
        div_req.start    = in_acc && need_div;
        div_req.dividend = DIVIDEND_W'(r_rem) + DIVIDEND_W'(r_rate);
        div_req.divisor  = in_tps;
    end

    aft_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = need_div ? S_DIV : S_WAIT;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (can_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration register decode.
    always_comb begin
        pready = 1'b1;
        cfg_wr = psel && penable && pwrite && pready
                 && (paddr[ADDR_W-1:2] == REG_AUDIO_RATE);
        prdata = (paddr[ADDR_W-1:2] == REG_AUDIO_RATE) ? APB_W'(r_rate) : '0;
    end

    // Control state, sample rate, remainder and total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= '0;
            r_rem       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                r_rate  <= pwdata[RATE_W-1:0];
                r_rem   <= '0;
                r_total <= '0;
            end else begin
                if (in_acc && (in_mode == MODE_RENDER)) begin
                    r_total <= r_total + TOTAL_WIDTH'(in_frames);
                end
                if ((r_state == S_DIV) && div_rsp.done) begin
                    r_rem <= div_rsp.remainder;
                end
            end
            if ((r_state == S_WAIT) && can_load) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: quotient held until the output register takes it.
    always_comb begin
        total_wide = 64'(r_total);
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_quot <= '0;
        end else if ((r_state == S_DIV) && div_rsp.done) begin
            r_quot <= div_rsp.quotient;
        end
        if ((r_state == S_WAIT) && can_load) begin
            r_out_data <= M_DATA_W'({(r_rate != '0), total_wide[EMIT_W-1:0], r_quot});
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

    // The divider only finishes while the sequencer waits for it.
    `AFT_ASSERT_IMP(a_done_in_div, i_clk, i_rst_n, div_rsp.done, r_state == S_DIV,
                    "stray divider done")
    // A tick item with both rates nonzero goes to the divider.
    `AFT_ASSERT_NXT(a_tick_divides, i_clk, i_rst_n, div_req.start,
                    r_state == S_DIV && div_rsp.busy, "division not started")
    // A finished result reaches the output register and frees the input.
    `AFT_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, (r_state == S_WAIT) && can_load,
                    r_out_valid && (r_state == S_IDLE), "result not loaded")

endmodule
